>>> rtl/mme_pkg.sv
// Shared types, constants and helper functions for the matrix multiply engine.
`timescale 1ns / 1ps
package mme_pkg;

  // Sizing
  localparam int MAX_DIM     = 8;
  localparam int ELEM_WIDTH  = 32;
  localparam int STORE_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = 4;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int PROD_W      = 2 * DATA_W;
  localparam int FRAC_BITS   = 16;
  localparam int RND_W       = PROD_W - FRAC_BITS;
  localparam int ACC_W       = 64;
  localparam int PADDR_W     = 4;

  // Commands
  localparam logic [1:0] CMD_LOAD_A   = 2'd0;
  localparam logic [1:0] CMD_LOAD_B   = 2'd1;
  localparam logic [1:0] CMD_MULTIPLY = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  // Control that travels alongside each multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_elem;
  } mme_tag_t;

  // Zero acts as one, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // Keep the low ELEM_WIDTH bits and sign extend
  function automatic logic signed [DATA_W-1:0] extend_elem(input logic [DATA_W-1:0] v);
    logic signed [ELEM_WIDTH-1:0] t;
    t = v[ELEM_WIDTH-1:0];
    return DATA_W'(t);
  endfunction

endpackage

>>> rtl/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mme_seq.sv
// Sequencer walking row, column and inner index and issuing store addresses.
`timescale 1ns / 1ps
module mme_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [mme_pkg::DIM_W-1:0]  rows_a,
  input  logic [mme_pkg::DIM_W-1:0]  inner_dim,
  input  logic [mme_pkg::DIM_W-1:0]  cols_b,
  output logic [mme_pkg::ADDR_W-1:0] a_addr,
  output logic [mme_pkg::ADDR_W-1:0] b_addr,
  output mme_pkg::mme_tag_t          tag,
  output logic                       running
);
  import mme_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t       state;
  logic [IDX_W-1:0] i_idx, j_idx, k_idx;
  logic [IDX_W-1:0] m_last, n_last, o_last;
  logic [DIM_W-1:0] n_dim, o_dim;
  logic [ADDR_W-1:0] row_base;
  logic             k_end, j_end, i_end;

  assign k_end = (k_idx == n_last);
  assign j_end = (j_idx == o_last);
  assign i_end = (i_idx == m_last);

  // Tag for the step being addressed this cycle
  always_comb begin
    tag           = '0;
    tag.valid     = (state == ST_RUN);
    tag.first     = (k_idx == '0);
    tag.last_k    = k_end;
    tag.row       = i_idx;
    tag.col       = j_idx;
    tag.last_elem = i_end && j_end;
  end

  assign running = (state == ST_RUN);

  // Counter and address walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (go) begin
            state    <= ST_RUN;
            i_idx    <= '0;
            j_idx    <= '0;
            k_idx    <= '0;
            a_addr   <= '0;
            b_addr   <= '0;
            row_base <= '0;
            n_dim    <= clamp_dim(inner_dim);
            o_dim    <= clamp_dim(cols_b);
            m_last   <= IDX_W'(clamp_dim(rows_a) - DIM_W'(1));
            n_last   <= IDX_W'(clamp_dim(inner_dim) - DIM_W'(1));
            o_last   <= IDX_W'(clamp_dim(cols_b) - DIM_W'(1));
          end
        end
        ST_RUN: begin
          if (!k_end) begin
            k_idx  <= k_idx + IDX_W'(1);
            a_addr <= a_addr + ADDR_W'(1);
            b_addr <= b_addr + ADDR_W'(o_dim);
          end else begin
            k_idx <= '0;
            if (!j_end) begin
              j_idx  <= j_idx + IDX_W'(1);
              a_addr <= row_base;
              b_addr <= ADDR_W'(j_idx) + ADDR_W'(1);
            end else begin
              j_idx  <= '0;
              b_addr <= '0;
              if (i_end) begin
                state <= ST_IDLE;
              end else begin
                i_idx    <= i_idx + IDX_W'(1);
                row_base <= row_base + ADDR_W'(n_dim);
                a_addr   <= row_base + ADDR_W'(n_dim);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_go_from_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && go |=> (state == ST_RUN))
    else $error("multiply start did not enter run");
  a_run_starts_fresh: assert property (@(posedge clk) disable iff (rst)
    $rose(running) |-> (k_idx == '0) && (j_idx == '0) && (i_idx == '0))
    else $error("run began with nonzero counters");
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(running) |-> $past(tag.last_elem && tag.last_k))
    else $error("run ended before the last element");
`endif

endmodule

>>> rtl/mme_mac.sv
// Shared multiply-accumulate pipeline: multiply, round, accumulate, saturate.
`timescale 1ns / 1ps
module mme_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  mme_pkg::mme_tag_t          tag_in,
  input  logic [mme_pkg::DATA_W-1:0] a_data,
  input  logic [mme_pkg::DATA_W-1:0] b_data,
  output logic                       pipe_busy,
  output logic                       out_valid,
  output logic [mme_pkg::DATA_W-1:0] out_value,
  output logic [mme_pkg::IDX_W-1:0]  out_row_q,
  output logic [mme_pkg::IDX_W-1:0]  out_col_q,
  output logic                       out_last
);
  import mme_pkg::*;

  mme_tag_t                  t1, t2, t3, t4;
  logic signed [PROD_W-1:0]  prod;
  logic signed [RND_W-1:0]   rnd;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_next;
  logic signed [PROD_W-1:0]  prod_rounded;
  logic [DATA_W-1:0]         sat_value;

  assign pipe_busy = t1.valid | t2.valid | t3.valid | t4.valid;

  // Tag pipeline, t1 lines up with the registered store read
  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
    end else begin
      t1 <= tag_in;
      t2 <= t1;
      t3 <= t2;
      t4 <= t3;
    end
  end

  // Multiply, then round Q32.32 to Q32.16 (nearest, ties up)
  assign prod_rounded = (prod + PROD_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    prod <= $signed(a_data) * $signed(b_data);
    rnd  <= prod_rounded[RND_W-1:0];
  end

  // Accumulate, cleared on the first step of each element
  assign acc_next = (t3.first ? ACC_W'(0) : acc) + {{(ACC_W - RND_W){rnd[RND_W-1]}}, rnd};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (t3.valid) begin
      acc <= acc_next;
    end
  end

  // Saturate to 32 bits
  always_comb begin
    if (acc[ACC_W-1] && !(&acc[ACC_W-2:DATA_W-1])) begin
      sat_value = {1'b1, {(DATA_W - 1){1'b0}}};
    end else if (!acc[ACC_W-1] && (|acc[ACC_W-2:DATA_W-1])) begin
      sat_value = {1'b0, {(DATA_W - 1){1'b1}}};
    end else begin
      sat_value = acc[DATA_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= t4.valid && t4.last_k;
    end
    out_value <= sat_value;
    out_row_q <= t4.row;
    out_col_q <= t4.col;
    out_last  <= t4.last_elem;
  end

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(t4.valid && t4.last_k))
    else $error("result strobe without a finished element");
  a_steps_contiguous: assert property (@(posedge clk) disable iff (rst)
    (t1.valid && !t1.first) |-> $past(t1.valid))
    else $error("gap inside one element's accumulation");
  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |=> !out_valid)
    else $error("result right after the final element");
`endif

endmodule

>>> rtl/matrix_multiply_engine.sv
// Top level: configuration port, element stores, sequencer and shared MAC.
`timescale 1ns / 1ps
// A load command (A or B) writes one element in the cycle it is taken and
// leaves busy low, so loads can go in every cycle while no multiply holds
// busy high. A multiply command raises busy while its M*N*O inner-product
// steps are being issued or are in the pipeline, where M, N, O are the
// clamped rows_a, inner_dim and cols_b: the one shared 32x32 multiplier
// takes one inner-product step per cycle, followed by a five-stage pipeline
// (store read, multiply, round, accumulate, saturate). Product elements come
// out in row-major order, each on out_valid for exactly one cycle; the
// receiver cannot stall them and last marks the final one. Reading a store
// entry that was never loaded gives an arbitrary value.
module matrix_multiply_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mme_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        cmd,
  input  logic [mme_pkg::ADDR_W-1:0]        elem_index,
  input  logic signed [mme_pkg::DATA_W-1:0] elem_value,
  output logic                              out_valid,
  output logic signed [mme_pkg::DATA_W-1:0] product_value,
  output logic [mme_pkg::IDX_W-1:0]         out_row,
  output logic [mme_pkg::IDX_W-1:0]         out_col,
  output logic                              last
);
  import mme_pkg::*;

  logic [DIM_W-1:0]  rows_a, inner_dim, cols_b;
  logic              cfg_write;
  logic              accept;
  logic              we_a, we_b, go;
  logic [DATA_W-1:0] wr_data;
  logic [ADDR_W-1:0] a_addr, b_addr;
  logic [DATA_W-1:0] a_data, b_data;
  mme_tag_t          tag;
  logic              running, pipe_busy;
  logic [DATA_W-1:0] out_value;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_W'(1);
      inner_dim <= DIM_W'(1);
      cols_b    <= DIM_W'(1);
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_ROWS_A:    rows_a    <= pwdata[DIM_W-1:0];
        REG_INNER_DIM: inner_dim <= pwdata[DIM_W-1:0];
        REG_COLS_B:    cols_b    <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS_A:    prdata = 32'(rows_a);
      REG_INNER_DIM: prdata = 32'(inner_dim);
      REG_COLS_B:    prdata = 32'(cols_b);
      default:       prdata = '0;
    endcase
  end

  // Command decode
  assign busy    = running | pipe_busy;
  assign accept  = start && !busy;
  assign we_a    = accept && (cmd == CMD_LOAD_A);
  assign we_b    = accept && (cmd == CMD_LOAD_B);
  assign go      = accept && (cmd == CMD_MULTIPLY);
  assign wr_data = extend_elem(elem_value);

  // Element stores
  mme_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (elem_index),
    .wdata (wr_data),
    .raddr (a_addr),
    .rdata (a_data)
  );

  mme_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (elem_index),
    .wdata (wr_data),
    .raddr (b_addr),
    .rdata (b_data)
  );

  // Sequencer
  mme_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .rows_a    (rows_a),
    .inner_dim (inner_dim),
    .cols_b    (cols_b),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .tag       (tag),
    .running   (running)
  );

  // Shared multiply-accumulate
  mme_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .tag_in    (tag),
    .a_data    (a_data),
    .b_data    (b_data),
    .pipe_busy (pipe_busy),
    .out_valid (out_valid),
    .out_value (out_value),
    .out_row_q (out_row),
    .out_col_q (out_col),
    .out_last  (last)
  );

  assign product_value = out_value;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for matrix_multiply_engine: directed table, random jobs, APB config.
`timescale 1ns / 1ps
module tb_top;
  import mme_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS   = 325;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_DIRECTED   = 25;
  localparam int NUM_PRESETS    = 5;

  // One element of the product as it leaves the block
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     last;
  } prod_elem_t;

  // One row of the directed table
  typedef struct {
    logic [1:0]  op;
    logic [5:0]  idx;
    logic [31:0] val;
    bit          typed;
    logic [31:0] want;
  } stim_row_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [PADDR_W-1:0]         paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       start;
  logic                       busy;
  logic [1:0]                 cmd;
  logic [ADDR_W-1:0]          elem_index;
  logic signed [DATA_W-1:0]   elem_value;
  logic                       out_valid;
  logic signed [DATA_W-1:0]   product_value;
  logic [IDX_W-1:0]           out_row;
  logic [IDX_W-1:0]           out_col;
  logic                       last;

  // Predictor state: copies of both stores and the raw size registers
  logic signed [DATA_W-1:0] shadow_a [STORE_DEPTH];
  logic signed [DATA_W-1:0] shadow_b [STORE_DEPTH];
  bit                       loaded_a [STORE_DEPTH];
  bit                       loaded_b [STORE_DEPTH];
  logic [DIM_W-1:0]         dim_rows;
  logic [DIM_W-1:0]         dim_inner;
  logic [DIM_W-1:0]         dim_cols;

  prod_elem_t pending_products[$];
  stim_row_t  directed_rows [NUM_DIRECTED];
  int         errors;
  int         items_sent;
  int         idle_pct;
  int         idle_cycles;

  matrix_multiply_engine uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .elem_index    (elem_index),
    .elem_value    (elem_value),
    .out_valid     (out_valid),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Size register as the block uses it: zero acts as one, capped at MAX_DIM
  function automatic int active_dim(input logic [DIM_W-1:0] v);
    int d;
    d = int'(v);
    if (d < 1) d = 1;
    if (d > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

  // Keep the low ELEM_WIDTH bits of a loaded value, sign extended
  function automatic logic signed [DATA_W-1:0] narrow_elem(input logic [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] t;
    t = v << (DATA_W - ELEM_WIDTH);
    t = t >>> (DATA_W - ELEM_WIDTH);
    return t;
  endfunction

  // Every element of C = A x B in row-major order, Q16.16 with rounding and saturation
  function automatic void compute_product();
    int m;
    int n;
    int o;
    logic signed [63:0] acc;
    logic signed [63:0] pa;
    logic signed [63:0] pb;
    logic signed [63:0] term;
    prod_elem_t r;
    m = active_dim(dim_rows);
    n = active_dim(dim_inner);
    o = active_dim(dim_cols);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < o; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) begin
          pa = shadow_a[(n * i + k) % STORE_DEPTH];
          pb = shadow_b[(o * k + j) % STORE_DEPTH];
          term = pa * pb;
          acc = acc + ((term + 64'sd32768) >>> FRAC_BITS);
        end
        if (acc > 64'sd2147483647) r.value = 32'sh7FFFFFFF;
        else if (acc < -64'sd2147483648) r.value = 32'sh80000000;
        else r.value = acc[DATA_W-1:0];
        r.row = IDX_W'(i);
        r.col = IDX_W'(j);
        r.last = (i == m - 1) && (j == o - 1);
        pending_products.push_back(r);
      end
    end
  endfunction

  // Update the predictor for one accepted item
  function automatic void apply_item(input logic [1:0] c, input logic [5:0] ix,
                                     input logic [31:0] v, input bit typed,
                                     input logic [31:0] want);
    prod_elem_t r;
    case (c)
      CMD_LOAD_A: begin
        shadow_a[ix] = narrow_elem(v);
        loaded_a[ix] = 1'b1;
      end
      CMD_LOAD_B: begin
        shadow_b[ix] = narrow_elem(v);
        loaded_b[ix] = 1'b1;
      end
      CMD_MULTIPLY: begin
        if (typed) begin
          // directed rows run at 1x1x1: one element, row 0, col 0, marked last
          r.value = want;
          r.row = '0;
          r.col = '0;
          r.last = 1'b1;
          pending_products.push_back(r);
        end else begin
          compute_product();
        end
      end
      default: ;
    endcase
  endfunction

  // Element value mix: extremes, full range, and small/medium Q16.16 values
  function automatic logic [31:0] pick_value();
    int sel;
    logic [31:0] v;
    sel = $urandom_range(9);
    case (sel)
      0: v = 32'h80000000;
      1: v = 32'h7FFFFFFF;
      2, 3: v = $urandom;
      4, 5: v = $urandom_range(0, 32'h01FFFFFF) - 32'h01000000;
      default: v = $urandom_range(0, 32'h001FFFFF) - 32'h00100000;
    endcase
    return v;
  endfunction

  // Present one item, hold it until taken, then predict it
  task automatic send_item(input logic [1:0] c, input logic [5:0] ix, input logic [31:0] v,
                           input bit typed = 1'b0, input logic [31:0] want = '0);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    cmd        <= c;
    elem_index <= ix;
    elem_value <= v;
    do @(posedge clk); while (busy);
    items_sent++;
    apply_item(c, ix, v, typed, want);
  endtask

  // Hold off the sender until every expected element has come and the block is quiet
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_products.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of one size register, junk in the unused upper bits
  task automatic write_dim(input logic [1:0] reg_idx, input logic [DIM_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({reg_idx, 2'b00});
    pwdata  <= {28'($urandom), v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      REG_ROWS_A:    dim_rows  = v;
      REG_INNER_DIM: dim_inner = v;
      REG_COLS_B:    dim_cols  = v;
      default: ;
    endcase
  endtask

  // APB read back of one size register, low bits compared
  task automatic check_dim(input logic [1:0] reg_idx, input logic [DIM_W-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'({reg_idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[DIM_W-1:0] !== want) begin
      $display("%0t: register %0d readback expected %0d actual %0d",
               $time, reg_idx, want, prdata[DIM_W-1:0]);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                          input logic [DIM_W-1:0] c);
    write_dim(REG_ROWS_A, r);
    write_dim(REG_INNER_DIM, k);
    write_dim(REG_COLS_B, c);
    check_dim(REG_ROWS_A, r);
    check_dim(REG_INNER_DIM, k);
    check_dim(REG_COLS_B, c);
  endtask

  // Load any store entry the next multiply reads that was never written
  task automatic fill_missing();
    int m;
    int n;
    int o;
    m = active_dim(dim_rows);
    n = active_dim(dim_inner);
    o = active_dim(dim_cols);
    for (int i = 0; i < m * n; i++)
      if (!loaded_a[i]) send_item(CMD_LOAD_A, 6'(i), pick_value());
    for (int i = 0; i < n * o; i++)
      if (!loaded_b[i]) send_item(CMD_LOAD_B, 6'(i), pick_value());
  endtask

  // Output checker and watchdog
  always @(posedge clk) begin
    prod_elem_t exp_elem;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("** matrix_multiply_engine: FAILED **");
        $finish;
      end
      if (out_valid) begin
        if (pending_products.size() == 0) begin
          $display("%0t: unexpected element expected none actual value %h row %0d col %0d",
                   $time, product_value, out_row, out_col);
          errors++;
        end else begin
          exp_elem = pending_products.pop_front();
          if (product_value !== exp_elem.value) begin
            $display("%0t: product_value expected %h actual %h",
                     $time, exp_elem.value, product_value);
            errors++;
          end
          if (out_row !== exp_elem.row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, exp_elem.row, out_row);
            errors++;
          end
          if (out_col !== exp_elem.col) begin
            $display("%0t: out_col expected %0d actual %0d", $time, exp_elem.col, out_col);
            errors++;
          end
          if (last !== exp_elem.last) begin
            $display("%0t: last expected %0b actual %0b", $time, exp_elem.last, last);
            errors++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [DIM_W-1:0] preset_rows  [NUM_PRESETS];
    logic [DIM_W-1:0] preset_inner [NUM_PRESETS];
    logic [DIM_W-1:0] preset_cols  [NUM_PRESETS];
    int job;
    int m;
    int n;
    int o;
    int cnt;
    logic [DIM_W-1:0] rv;
    logic [DIM_W-1:0] kv;
    logic [DIM_W-1:0] cv;

    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    start      = 1'b0;
    cmd        = CMD_LOAD_A;
    elem_index = '0;
    elem_value = '0;
    errors     = 0;
    items_sent = 0;
    idle_pct   = 0;
    dim_rows   = DIM_W'(1);
    dim_inner  = DIM_W'(1);
    dim_cols   = DIM_W'(1);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      shadow_a[i] = '0;
      shadow_b[i] = '0;
      loaded_a[i] = 1'b0;
      loaded_b[i] = 1'b0;
    end

    // Sizes at reset are 1x1x1, so each multiply below yields one element
    directed_rows = '{
      '{CMD_LOAD_A,   6'd0,  32'h00010000, 1'b0, 32'h0},
      '{CMD_LOAD_B,   6'd0,  32'h00020000, 1'b0, 32'h0},
      '{CMD_MULTIPLY, 6'd0,  32'h0,        1'b1, 32'h00020000},
      '{CMD_LOAD_A,   6'd0,  32'h7FFFFFFF, 1'b0, 32'h0},
      '{CMD_LOAD_B,   6'd0,  32'h7FFFFFFF, 1'b0, 32'h0},
      '{CMD_MULTIPLY, 6'd63, 32'hFFFFFFFF, 1'b1, 32'h7FFFFFFF},
      '{CMD_LOAD_A,   6'd0,  32'h80000000, 1'b0, 32'h0},
      '{CMD_MULTIPLY, 6'd0,  32'h0,        1'b1, 32'h80000000},
      '{CMD_LOAD_B,   6'd0,  32'h80000000, 1'b0, 32'h0},
      '{CMD_MULTIPLY, 6'd0,  32'h0,        1'b1, 32'h7FFFFFFF},
      // rounding ties: +0.5 LSB goes up, -0.5 LSB goes up to zero
      '{CMD_LOAD_A,   6'd0,  32'h00000001, 1'b0, 32'h0},
      '{CMD_LOAD_B,   6'd0,  32'h00008000, 1'b0, 32'h0},
      '{CMD_MULTIPLY, 6'd0,  32'h0,        1'b1, 32'h00000001},
      '{CMD_LOAD_A,   6'd0,  32'hFFFFFFFF, 1'b0, 32'h0},
      '{CMD_MULTIPLY, 6'd0,  32'h0,        1'b1, 32'h00000000},
      '{CMD_LOAD_B,   6'd0,  32'h00008001, 1'b0, 32'h0},
      '{CMD_MULTIPLY, 6'd0,  32'h0,        1'b1, 32'hFFFFFFFF},
      // loads past the matrix and the unused command must not disturb the product
      '{CMD_LOAD_A,   6'd63, 32'h12345678, 1'b0, 32'h0},
      '{CMD_LOAD_B,   6'd63, 32'hEDCBA987, 1'b0, 32'h0},
      '{CMD_UNUSED,   6'd42, 32'h55555555, 1'b0, 32'h0},
      '{CMD_LOAD_A,   6'd0,  32'h00000000, 1'b0, 32'h0},
      '{CMD_MULTIPLY, 6'd0,  32'h0,        1'b1, 32'h00000000},
      '{CMD_LOAD_A,   6'd0,  32'h00018000, 1'b0, 32'h0},
      '{CMD_LOAD_B,   6'd0,  32'hFFFE0000, 1'b0, 32'h0},
      '{CMD_MULTIPLY, 6'd21, 32'hAAAAAAAA, 1'b1, 32'hFFFD0000}
    };

    // Size settings walked first: zero, above the cap, single, full, uneven
    preset_rows  = '{4'd0, 4'd15, 4'd1,  4'd8, 4'd2};
    preset_inner = '{4'd0, 4'd1,  4'd15, 4'd8, 4'd3};
    preset_cols  = '{4'd0, 4'd15, 4'd1,  4'd8, 4'd4};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].want);

    // Random jobs: refresh part of A and B, then multiply
    job = 0;
    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      // Phases: no idling, sender idle, receiver stall (cannot happen), both
      case (job % 4)
        0: idle_pct = 0;
        1: idle_pct = 77;
        2: idle_pct = 0;
        default: idle_pct = 6;
      endcase
      if (job < NUM_PRESETS || $urandom_range(5) == 0) begin
        drain_results();
        if (job < NUM_PRESETS) begin
          rv = preset_rows[job];
          kv = preset_inner[job];
          cv = preset_cols[job];
        end else begin
          rv = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(5, 15))
                                        : DIM_W'($urandom_range(0, 4));
          kv = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(5, 15))
                                        : DIM_W'($urandom_range(0, 4));
          cv = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(5, 15))
                                        : DIM_W'($urandom_range(0, 4));
        end
        set_dims(rv, kv, cv);
      end else if ($urandom_range(9) == 0) begin
        drain_results();
      end
      m = active_dim(dim_rows);
      n = active_dim(dim_inner);
      o = active_dim(dim_cols);

      cnt = $urandom_range(1, (m * n < 6) ? m * n : 6);
      repeat (cnt) send_item(CMD_LOAD_A, 6'($urandom_range(0, m * n - 1)), pick_value());
      cnt = $urandom_range(1, (n * o < 6) ? n * o : 6);
      repeat (cnt) send_item(CMD_LOAD_B, 6'($urandom_range(0, n * o - 1)), pick_value());

      // Noise: unused command or a load anywhere in the store
      if ($urandom_range(5) == 0) begin
        case ($urandom_range(2))
          0: send_item(CMD_UNUSED, 6'($urandom_range(0, 63)), $urandom);
          1: send_item(CMD_LOAD_A, 6'($urandom_range(0, 63)), pick_value());
          default: send_item(CMD_LOAD_B, 6'($urandom_range(0, 63)), pick_value());
        endcase
      end

      fill_missing();
      send_item(CMD_MULTIPLY, 6'($urandom_range(0, 63)), $urandom);
      job++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (pending_products.size() != 0) begin
      $display("%0t: %0d elements expected actual none", $time, pending_products.size());
      errors++;
    end

    if (errors == 0) begin
      $display("** matrix_multiply_engine: PASSED **");
    end else begin
      $display("** matrix_multiply_engine: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mme_pkg.sv
rtl/mme_ram.sv
rtl/mme_seq.sv
rtl/mme_mac.sv
rtl/matrix_multiply_engine.sv
verif/tb_top.sv
